// ----- hdl/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants and types for the Scharr gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int PIX_W          = 16;
    localparam int MAG_W          = 16;
    localparam int FW_W           = 12;
    localparam int FH_W           = 13;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int COL_W          = 11;
    localparam int ROW_W          = 12;
    localparam int MAX_HEIGHT     = 4096;
    localparam int FW_RESET       = 640;
    localparam int FH_RESET       = 480;
    localparam int GRAD_W         = 22;   // signed gradient, |g| <= 16*65535
    localparam int SQ_W           = 43;   // gx^2 + gy^2
    localparam int ROOT_W         = 22;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // magnitude unit states
    typedef enum logic [1:0] {B_IDLE, B_SQ, B_ROOT, B_OUT} bst_t;

    // one window, classified by the front end
    typedef struct packed {
        logic [PIX_W-1:0] lt, lm, lb, ct, cb, rt, rm, rb;
        logic             row_end;
        logic             frame_end;
    } win_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             row_end;
        logic             frame_end;
    } res_t;

endpackage

// ----- hdl/scharr_gradient_magnitude_3x3.sv -----
// ----------------------------------------------------------------------------
// scharr_gradient_magnitude_3x3
// Scharr 3x3 gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// An interior pixel passes 2 front stages, the queue, gradient and square
//   registers, and 22 root steps. Border pixels go 1 per cycle while the
//   front's output slot is free or draining; the square-root unit, two operand
//   bits per cycle, takes a new window only after its last result is taken.
// Reset: aresetn synchronous active low; clears counters and handshakes,
//   registers return to 640 x 480; line stores are not cleared.
module scharr_gradient_magnitude_3x3
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,    // [15:0] pixel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [MAG_W-1:0]     m_tdata,    // [15:0] magnitude
    output logic                 m_tlast,    // row_end
    output logic                 m_tuser     // frame_end
);
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic            wv, wr, qv, qr;
    win_t            wd, qd;
    res_t            rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FW_W'(FW_RESET);
            fh_reg <= FH_W'(FH_RESET);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // front: line stores, window and border classification
    sgm_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
        .aclk, .aresetn, .frame_width(fw_reg), .frame_height(fh_reg),
        .pix_valid(s_tvalid), .pix_ready(s_tready), .pix(s_tdata),
        .win_valid(wv), .win_ready(wr), .win(wd));

    sgm_fifo u_fifo (
        .aclk, .aresetn, .in_valid(wv), .in_ready(wr), .in_data(wd),
        .out_valid(qv), .out_ready(qr), .out_data(qd));

    // back: gradient, squares and root; result held until transfer
    sgm_back u_back (
        .aclk, .aresetn, .in_valid(qv), .in_ready(qr), .in_data(qd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(rd));

    assign m_tdata = rd.magnitude;
    assign m_tlast = rd.row_end;
    assign m_tuser = rd.frame_end;
endmodule

// ----- hdl/sgm_ram.sv -----
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hdl/sgm_front.sv -----
// ----------------------------------------------------------------------------
// sgm_front
// Accepts pixels, keeps line stores, counters and window, emits interior windows.
// ----------------------------------------------------------------------------
module sgm_front
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [FW_W-1:0]  frame_width,
    input  logic [FH_W-1:0]  frame_height,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  logic [PIX_W-1:0] pix,
    output logic             win_valid,
    input  logic             win_ready,
    output win_t             win
);
    localparam int AW = $clog2(MAX_WIDTH);

    // stage 1: pixel accepted, store read in flight
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_inr_reg;
    logic             s1_rend_reg, s1_fend_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] w_reg [6];
    logic             out_valid_reg;
    win_t             out_reg;

    logic [PIX_W-1:0] top_rd, mid_rd, top_v, mid_v, pix_m;
    logic [13:0]      wd, ht;
    logic             acc, adv, rend, fend, inr;

    assign wd = (frame_width < FW_W'(3)) ? 14'd3 :
                ({2'b0, frame_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {2'b0, frame_width};
    assign ht = (frame_height < FH_W'(3)) ? 14'd3 :
                ({1'b0, frame_height} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {1'b0, frame_height};

    // stage 1 can advance when the output slot is free or draining
    assign adv       = !out_valid_reg || win_ready;
    assign pix_ready = adv;
    assign acc       = pix_valid && pix_ready;
    assign pix_m     = pix & PIX_W'((32'd1 << PIXEL_BITS) - 1);
    assign rend      = ({3'b0, col_reg} + 14'd1) >= wd;
    assign fend      = rend && (({2'b0, row_reg} + 14'd1) >= ht);
    assign inr       = 32'(col_reg) < MAX_WIDTH;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (rend) begin
                col_next = '0;
                row_next = fend ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // a read and a write at the same column never overlap in time except
    // back to back at width 1, which the clamp excludes; no bypass needed
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_one (
        .aclk, .we(s1_valid_reg && s1_inr_reg && adv), .waddr(s1_col_reg[AW-1:0]),
        .wdata(s1_pix_reg), .re(acc), .raddr(col_reg[AW-1:0]), .rdata(mid_rd));
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_two (
        .aclk, .we(s1_valid_reg && s1_inr_reg && adv), .waddr(s1_col_reg[AW-1:0]),
        .wdata(mid_v), .re(acc), .raddr(col_reg[AW-1:0]), .rdata(top_rd));

    assign top_v = s1_inr_reg ? top_rd : '0;
    assign mid_v = s1_inr_reg ? mid_rd : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv) begin
                s1_valid_reg  <= acc;
                out_valid_reg <= s1_valid_reg && s1_row_reg >= ROW_W'(2)
                                 && s1_col_reg >= COL_W'(2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_pix_reg  <= pix_m;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_inr_reg  <= inr;
            s1_rend_reg <= rend;
            s1_fend_reg <= fend;
        end
        if (adv && s1_valid_reg) begin
            out_reg.lt        <= w_reg[0];
            out_reg.lm        <= w_reg[1];
            out_reg.lb        <= w_reg[2];
            out_reg.ct        <= w_reg[3];
            out_reg.cb        <= w_reg[5];
            out_reg.rt        <= top_v;
            out_reg.rm        <= mid_v;
            out_reg.rb        <= s1_pix_reg;
            out_reg.row_end   <= s1_rend_reg;
            out_reg.frame_end <= s1_fend_reg;
            w_reg[0] <= w_reg[3];
            w_reg[1] <= w_reg[4];
            w_reg[2] <= w_reg[5];
            w_reg[3] <= top_v;
            w_reg[4] <= mid_v;
            w_reg[5] <= s1_pix_reg;
        end
    end

    assign win_valid = out_valid_reg;
    assign win       = out_reg;
endmodule

// ----- hdl/sgm_fifo.sv -----
// ----------------------------------------------------------------------------
// sgm_fifo
// Short window queue between front end and magnitude unit.
// ----------------------------------------------------------------------------
module sgm_fifo
    import sgm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  win_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output win_t out_data
);
    win_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= in_data;
    end
endmodule

// ----- hdl/sgm_back.sv -----
// ----------------------------------------------------------------------------
// sgm_back
// Gradients, squares and a two-bit-per-cycle iterative square root.
// ----------------------------------------------------------------------------
module sgm_back
    import sgm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  win_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);
    localparam int STEPS  = (SQ_W + 1) / 2;
    localparam int SW     = $clog2(STEPS + 1);
    localparam int SQ_PAD = 2 * STEPS;    // operand padded to whole bit pairs

    bst_t                     st_reg, st_next;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [SW-1:0]            k_reg;
    logic                     re_reg, fe_reg;
    logic [SQ_W-1:0]          sx, sy;
    logic [GRAD_W-1:0]        ax, ay;
    logic [SQ_W+1:0]          rem2, trial;
    logic                     fit;
    logic [SQ_PAD-1:0]        sq_reg;

    function automatic logic signed [GRAD_W-1:0] wsum(
        input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
        return GRAD_W'(3 * a) + GRAD_W'(10 * b) + GRAD_W'(3 * c);
    endfunction

    assign ax = gx_reg[GRAD_W-1] ? GRAD_W'(-gx_reg) : gx_reg;
    assign ay = gy_reg[GRAD_W-1] ? GRAD_W'(-gy_reg) : gy_reg;
    assign sx = SQ_W'(ax) * SQ_W'(ax);
    assign sy = SQ_W'(ay) * SQ_W'(ay);

    // digit step: bring down the top bit pair of sq_reg into the partial
    // remainder, try root*4+1 against it
    assign rem2  = {rem_reg[SQ_W-1:0], 2'b00} | (SQ_W+2)'(sq_reg[SQ_PAD-1:SQ_PAD-2]);
    assign trial = (SQ_W+2)'({root_reg, 2'b01});
    assign fit   = rem2 >= trial;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE: if (in_valid) st_next = B_SQ;
            B_SQ:   st_next = B_ROOT;
            B_ROOT: if (k_reg == SW'(STEPS - 1)) st_next = B_OUT;
            B_OUT:  if (out_ready) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    assign in_ready  = st_reg == B_IDLE;
    assign out_valid = st_reg == B_OUT;
    assign out_data.magnitude = MAG_W'(root_reg >> 5);
    assign out_data.row_end   = re_reg;
    assign out_data.frame_end = fe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= B_IDLE;
        else          st_reg <= st_next;
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            B_IDLE: if (in_valid) begin
                gx_reg <= wsum(in_data.rt, in_data.rm, in_data.rb)
                        - wsum(in_data.lt, in_data.lm, in_data.lb);
                gy_reg <= GRAD_W'(3 * in_data.lb) + GRAD_W'(10 * in_data.cb)
                        + GRAD_W'(3 * in_data.rb) - GRAD_W'(3 * in_data.lt)
                        - GRAD_W'(10 * in_data.ct) - GRAD_W'(3 * in_data.rt);
                re_reg <= in_data.row_end;
                fe_reg <= in_data.frame_end;
            end
            B_SQ: begin
                sq_reg   <= SQ_PAD'(sx) + SQ_PAD'(sy);
                rem_reg  <= '0;
                root_reg <= '0;
                k_reg    <= '0;
            end
            B_ROOT: begin
                sq_reg   <= {sq_reg[SQ_PAD-3:0], 2'b00};
                rem_reg  <= fit ? SQ_W'(rem2 - trial) : SQ_W'(rem2);
                root_reg <= {root_reg[ROOT_W-2:0], fit};
                k_reg    <= k_reg + SW'(1);
            end
            default: ;
        endcase
    end
endmodule

// ----- tb/sv/scharr_gradient_magnitude_3x3_test.sv -----
// ----------------------------------------------------------------------------
// scharr_gradient_magnitude_3x3_test
// Self-checking bench for the Scharr gradient magnitude block. Small frames
// of random and structured pixels are streamed in raster order with random
// gaps and stalls; a behavioral predictor computes each interior magnitude
// and its row/frame end flags, and every result transfer is compared.
// ----------------------------------------------------------------------------
module scharr_gradient_magnitude_3x3_test
    import sgm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PIXEL_BUDGET = 1850;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [PIX_W-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [MAG_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    always #1 aclk = ~aclk;

    scharr_gradient_magnitude_3x3 dut (.*);

    // predictor state
    int unsigned       width_reg, height_reg;
    logic [PIX_W-1:0]  row1_store [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  row2_store [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]  win [6];
    int unsigned       col_cnt, row_cnt;

    res_t              pending_mags [$];
    int                errors = 0;
    int unsigned       results_seen = 0;
    int unsigned       pixels_sent = 0;
    int unsigned       frames_done = 0;
    bit                long_stall = 1'b0;
    bit                stall_done = 1'b0;

    // integer square root, bit-serial
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the predictor by one pixel; queue the magnitude if interior
    task automatic predict_magnitude(input logic [PIX_W-1:0] pix);
        int unsigned     w, h;
        logic [PIX_W-1:0] top, mid;
        longint          gx, gy;
        res_t            r;
        w = clamp(width_reg, MAX_WIDTH_DEF);
        h = clamp(height_reg, MAX_HEIGHT);
        top = row2_store[col_cnt];
        mid = row1_store[col_cnt];
        row2_store[col_cnt] = mid;
        row1_store[col_cnt] = pix;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            gx = 3 * longint'(top) + 10 * longint'(mid) + 3 * longint'(pix)
               - 3 * longint'(win[0]) - 10 * longint'(win[1]) - 3 * longint'(win[2]);
            gy = 3 * (longint'(win[2]) - longint'(win[0]))
               + 10 * (longint'(win[5]) - longint'(win[3]))
               + 3 * (longint'(pix) - longint'(top));
            r.magnitude = MAG_W'(int_sqrt(longint'(gx * gx + gy * gy)) >> 5);
            r.row_end   = (col_cnt + 1 >= w);
            r.frame_end = r.row_end && (row_cnt + 1 >= h);
            pending_mags.push_back(r);
        end
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = top;    win[4] = mid;    win[5] = pix;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
                frames_done++;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    // one pixel transfer, with a random lead-in gap; tvalid stays high
    // between pixels sent back to back
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        predict_magnitude(pix);
        pixels_sent++;
    endtask

    // drop tvalid and wait until every expected result has arrived
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_mags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write while idle; counters are at the frame start by then
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_FRAME_WIDTH) width_reg = val & 12'hFFF;
        else height_reg = val & 13'h1FFF;
    endtask

    // pixel pattern for a frame: 0 random, 1 extremes, 2 vertical edge,
    // 3 horizontal edge, 4 single bits
    function automatic logic [PIX_W-1:0] frame_pixel(int kind, int unsigned c,
                                                     int unsigned r);
        case (kind)
            1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            2: return (c[0] ^ c[1]) ? 16'hFFFF : 16'h0000;
            3: return r[0] ? 16'hFFFF : 16'h0000;
            4: return 16'h1 << $urandom_range(0, 15);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_frame(int kind);
        int unsigned n, w, h;
        w = clamp(width_reg, MAX_WIDTH_DEF);
        h = clamp(height_reg, MAX_HEIGHT);
        for (n = 0; n < w * h; n++) send_pixel(frame_pixel(kind, n % w, n / w));
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned k;
        forever begin
            @(posedge aclk);
            if (long_stall && !stall_done) begin
                m_tready <= 1'b0;
                for (k = 0; k < 400; k++) @(posedge aclk);
                stall_done = 1'b1;
            end
            m_tready <= ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(0, 14)) @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_mags.size() == 0) begin
                $error("unexpected result transfer, magnitude %0d", m_tdata);
                errors++;
            end else begin
                e = pending_mags.pop_front();
                if (m_tdata !== e.magnitude) begin
                    $error("magnitude: expected %0d, got %0d", e.magnitude, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.row_end) begin
                    $error("row_end: expected %0b, got %0b", e.row_end, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", e.frame_end, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        int unsigned cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // directed frame settings: width, height, pattern kind
    typedef struct {
        int unsigned w;
        int unsigned h;
        int          kind;
    } frame_row_t;

    frame_row_t directed [] = '{
        '{3, 3, 1},      // smallest frame, one interior pixel
        '{4, 3, 2},      // vertical edges at full swing
        '{3, 4, 3},      // horizontal edges at full swing
        '{5, 4, 4}       // single set bits
    };

    initial begin
        int kind;
        width_reg = FW_RESET;
        height_reg = FH_RESET;
        col_cnt = 0;
        row_cnt = 0;
        foreach (win[i]) win[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames, flags checked by the predictor
        foreach (directed[i]) begin
            write_reg(REG_FRAME_WIDTH, directed[i].w);
            write_reg(REG_FRAME_HEIGHT, directed[i].h);
            send_frame(directed[i].kind);
            wait_idle();
        end

        // out-of-range settings clamp to 3 (below)
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 1);
        send_frame(0);
        wait_idle();

        // long receiver hold-off while pixels keep coming
        write_reg(REG_FRAME_WIDTH, 6);
        write_reg(REG_FRAME_HEIGHT, 8);
        long_stall = 1'b1;
        send_frame(0);
        wait_idle();

        // random small frames until the pixel budget is used; sizes change
        // only once the block has drained
        write_reg(REG_FRAME_WIDTH, $urandom_range(3, 12));
        write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 10));
        while (pixels_sent < PIXEL_BUDGET) begin
            kind = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            send_frame(kind);
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                write_reg(REG_FRAME_WIDTH, $urandom_range(3, 12));
                write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 10));
            end
        end
        wait_idle();

        $display("%0d pixels in %0d frames, %0d results checked", pixels_sent,
                 frames_done, results_seen);
        $display("edge patterns, low size clamps, long output stall, back-to-back frames");
        if (errors == 0 && pending_mags.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- scharr_gradient_magnitude_3x3.f -----
hdl/sgm_pkg.sv
hdl/sgm_ram.sv
hdl/sgm_front.sv
hdl/sgm_fifo.sv
hdl/sgm_back.sv
hdl/scharr_gradient_magnitude_3x3.sv
tb/sv/scharr_gradient_magnitude_3x3_test.sv
